FILE: rtl/uat_pkg.sv
// Shared types, widths, op codes and constants for the usage accounting table.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package uat_pkg;

   localparam int TABLE_DEPTH_DEF = 64;
   localparam int MAX_ROWS_DEF    = 64;

   localparam int OP_W       = 3;
   localparam int PID_W      = 23;
   localparam int TK_W       = 48;
   localparam int UID_W      = 32;
   localparam int TOT_W      = 54;
   localparam int CLK_W      = 14;
   localparam int SHR_W      = 14;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam int NUM_W      = TK_W + SHR_W;

   localparam logic [OP_W-1:0] OP_SAMPLE    = 3'd0;
   localparam logic [OP_W-1:0] OP_REPORT    = 3'd1;
   localparam logic [OP_W-1:0] OP_CLEAR_RUN = 3'd2;
   localparam logic [OP_W-1:0] OP_STOP      = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR_STP = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_CLK_TCK = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_APP_UID = 1'd1;

   localparam logic [CLK_W-1:0] CLK_TCK_RST = 14'd100;
   localparam logic [UID_W-1:0] APP_UID_RST = 32'd100000;

   // report threshold: ticks * THR_MUL > clk_tck
   localparam int THR_MUL = 200;
   localparam logic [SHR_W-1:0] SHARE_SCALE = 14'd10000;

   localparam logic [TK_W-1:0]  MAX48 = {TK_W{1'b1}};
   localparam logic [TOT_W-1:0] MAX54 = {TOT_W{1'b1}};

   typedef struct packed {
      logic [PID_W-1:0] pid;
      logic [TK_W-1:0]  start;
      logic [TK_W-1:0]  base;
      logic [TK_W-1:0]  last;
      logic [TK_W-1:0]  banked;
      logic             app;
   } entry_type;

endpackage

`default_nettype wire

FILE: rtl/uat_ifs.sv
// Channel interfaces: request, response and register write.
// Depends on uat_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface uat_req_if;
   logic                      valid;
   logic                      ready;
   logic [uat_pkg::OP_W-1:0]  op;
   logic [uat_pkg::PID_W-1:0] pid;
   logic [uat_pkg::TK_W-1:0]  start_ticks;
   logic [uat_pkg::TK_W-1:0]  ticks;
   logic [uat_pkg::UID_W-1:0] uid;
   modport source (output valid, op, pid, start_ticks, ticks, uid, input ready);
   modport sink   (input valid, op, pid, start_ticks, ticks, uid, output ready);
endinterface

interface uat_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      row_valid;
   logic [uat_pkg::PID_W-1:0] row_pid;
   logic [uat_pkg::TK_W-1:0]  cpu_ticks;
   logic [uat_pkg::SHR_W-1:0] share_hundredths;
   logic                      is_app;
   logic [uat_pkg::TOT_W-1:0] total_ticks;
   logic                      table_full;
   logic                      last;
   modport source (output valid, row_valid, row_pid, cpu_ticks, share_hundredths, is_app,
                   total_ticks, table_full, last, input ready);
   modport sink   (input valid, row_valid, row_pid, cpu_ticks, share_hundredths, is_app,
                   total_ticks, table_full, last, output ready);
endinterface

interface uat_csr_if;
   logic                           valid;
   logic                           ready;
   logic [uat_pkg::CSR_IDX_W-1:0]  index;
   logic [uat_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/per_id_usage_accounting_table_top.sv
// Per-process tick accounting table, top level.
// Depends on uat_pkg, uat_ifs (channels), uat_mem (entry store), uat_div (share divider).
//
// Keeps up to TABLE_DEPTH accounts of CPU ticks keyed by process id in a single-port-read
// memory, scanned one entry per clock through a short read pipeline. A transaction on req_ch
// is taken only while the control sequencer is idle. Stop, clear and unused op codes complete
// in the idle state, and a sample while stopped is dropped. A sample makes one full walk of
// the memory read port looking for the id and for the lowest free entry, then a read-modify-
// write; a new id is written straight to the free entry, or sets the full flag if none is
// free. A report makes one walk to form the total, then for every emitted row another walk
// to select the next row in rank order and the 14-step share division; an empty report emits
// one empty row. Result transactions go through an output register, so a finished row can
// wait on rsp_ch while the next is being worked out. Clears reset the valid bits; the memory
// itself is not cleared and needs no pass after reset. csr_ch is always ready; write it only
// while no transaction is in progress.
`timescale 1ns / 1ps
`default_nettype none

module per_id_usage_accounting_table_top #(
   parameter int TABLE_DEPTH = uat_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_ROWS    = uat_pkg::MAX_ROWS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   uat_req_if.sink   req_ch,
   uat_rsp_if.source rsp_ch,
   uat_csr_if.sink   csr_ch
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
   localparam logic [CW-1:0] ROW_CAP  = (MAX_ROWS < TABLE_DEPTH) ? CW'(MAX_ROWS)
                                                                 : CW'(TABLE_DEPTH);

   localparam int TK_W  = uat_pkg::TK_W;
   localparam int TOT_W = uat_pkg::TOT_W;
   localparam int PID_W = uat_pkg::PID_W;
   localparam int SHR_W = uat_pkg::SHR_W;

   // sequencer states
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SCAN_S = 4'd1;  // sample lookup walk
   localparam logic [3:0] ST_UPD1   = 4'd2;
   localparam logic [3:0] ST_UPD2   = 4'd3;
   localparam logic [3:0] ST_SCAN_T = 4'd4;  // report total walk
   localparam logic [3:0] ST_SCAN_R = 4'd5;  // report selection walk
   localparam logic [3:0] ST_MUL    = 4'd6;
   localparam logic [3:0] ST_DIV    = 4'd7;
   localparam logic [3:0] ST_EMIT   = 4'd8;

   logic [3:0] state_ff;

   // registers and mode
   logic [uat_pkg::CLK_W-1:0] clk_tck_ff;
   logic [uat_pkg::UID_W-1:0] app_thr_ff;
   logic                      running_ff;
   logic                      full_ff;
   logic [TABLE_DEPTH-1:0]    valid_ff;

   // latched sample
   logic [PID_W-1:0]          pid_ff;
   logic [TK_W-1:0]           start_ff;
   logic [TK_W-1:0]           ticks_ff;
   logic [uat_pkg::UID_W-1:0] uid_ff;

   // read issue
   logic          issue_ff;
   logic [AW-1:0] cnt_ff;
   logic          start_pass;

   // read pipeline
   logic             s1_vld_ff, s1_last_ff;
   logic [AW-1:0]    s1_idx_ff;
   logic             s2_vld_ff, s2_last_ff, s2_en_ff, s2_app_ff;
   logic [PID_W-1:0] s2_pid_ff;
   logic [TK_W-1:0]  s2_diff_ff, s2_banked_ff;
   logic             s3_vld_ff, s3_last_ff, s3_en_ff, s3_app_ff;
   logic [PID_W-1:0] s3_pid_ff;
   logic [TK_W-1:0]  s3_val_ff;
   logic [TK_W:0]    s2_sum;

   // sample bookkeeping
   logic               hit_found_ff, free_found_ff;
   logic [AW-1:0]      hit_idx_ff, free_idx_ff;
   uat_pkg::entry_type hit_data_ff;
   logic               zero_ff, chg_ff, gt_ff;
   logic [TK_W-1:0]    diff_u_ff;
   logic [TK_W:0]      bank_sum;
   logic               app_new;

   // report bookkeeping
   logic [TOT_W-1:0] total_ff;
   logic [TOT_W:0]   total_sum;
   logic [CW-1:0]    count_ff, count_nx, nrows_ff, rows_done_ff;
   logic             empty_ff;
   logic [TK_W-1:0]  prev_val_ff, best_val_ff;
   logic [PID_W-1:0] prev_pid_ff, best_pid_ff;
   logic             best_found_ff, best_app_ff;
   logic [SHR_W-1:0] share_ff;
   logic             qual, after_prev, before_best;

   // memory and divider
   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr;
   uat_pkg::entry_type wr_data, rd_data;
   logic               div_start, div_done;
   logic [SHR_W-1:0]   div_quot;

   // output register
   logic               rsp_valid_ff, rsp_row_valid_ff, rsp_is_app_ff, rsp_full_ff, rsp_last_ff;
   logic [PID_W-1:0]   rsp_pid_ff;
   logic [TK_W-1:0]    rsp_ticks_ff;
   logic [SHR_W-1:0]   rsp_share_ff;
   logic [TOT_W-1:0]   rsp_total_ff;
   logic               emit_fire, req_fire, last_row;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_tck_ff <= uat_pkg::CLK_TCK_RST;
         app_thr_ff <= uat_pkg::APP_UID_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            uat_pkg::CSR_CLK_TCK: clk_tck_ff <= csr_ch.data[uat_pkg::CLK_W-1:0];
            uat_pkg::CSR_APP_UID: app_thr_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------------------
   // Read issue and pipeline: s1 = memory data, s2 = run length, s3 = account value.
   // ---------------------------------------------------------------------------------------
   assign rd_en  = issue_ff;
   assign s2_sum = {1'b0, s2_banked_ff} + {1'b0, s2_diff_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff  <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         if (start_pass) begin
            issue_ff <= 1'b1;
            cnt_ff   <= '0;
         end else if (issue_ff) begin
            if (cnt_ff == LAST_IDX) begin
               issue_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         s1_vld_ff <= issue_ff;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff   <= (cnt_ff == LAST_IDX);
      s1_idx_ff    <= cnt_ff;
      s2_last_ff   <= s1_last_ff;
      s2_en_ff     <= valid_ff[s1_idx_ff];
      s2_pid_ff    <= rd_data.pid;
      s2_app_ff    <= rd_data.app;
      s2_diff_ff   <= (rd_data.last >= rd_data.base) ? rd_data.last - rd_data.base : '0;
      s2_banked_ff <= rd_data.banked;
      s3_last_ff   <= s2_last_ff;
      s3_en_ff     <= s2_en_ff;
      s3_pid_ff    <= s2_pid_ff;
      s3_app_ff    <= s2_app_ff;
      s3_val_ff    <= s2_sum[TK_W] ? uat_pkg::MAX48 : s2_sum[TK_W-1:0];
   end

   // qualifying row: val * 200 > clk_tck; any bit above 6 already clears the maximum
   assign qual = s3_en_ff &&
                 ((|s3_val_ff[TK_W-1:7]) ||
                  ((15'(s3_val_ff[6:0]) * 15'(uat_pkg::THR_MUL)) > 15'(clk_tck_ff)));
   assign after_prev  = (rows_done_ff == '0) || (s3_val_ff < prev_val_ff) ||
                        ((s3_val_ff == prev_val_ff) && (s3_pid_ff > prev_pid_ff));
   assign before_best = !best_found_ff || (s3_val_ff > best_val_ff) ||
                        ((s3_val_ff == best_val_ff) && (s3_pid_ff < best_pid_ff));
   assign total_sum   = {1'b0, total_ff} + (TOT_W + 1)'(s3_val_ff);
   assign count_nx    = count_ff + CW'(s3_vld_ff && qual);

   // ---------------------------------------------------------------------------------------
   // Sample write-back
   // ---------------------------------------------------------------------------------------
   assign app_new  = uid_ff >= app_thr_ff;
   assign bank_sum = {1'b0, hit_data_ff.banked} + {1'b0, diff_u_ff};

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = free_idx_ff;
      wr_data = hit_data_ff;
      if (state_ff == ST_UPD1 && !hit_found_ff && free_found_ff) begin
         wr_en          = 1'b1;
         wr_data.pid    = pid_ff;
         wr_data.start  = start_ff;
         wr_data.base   = ticks_ff;
         wr_data.last   = ticks_ff;
         wr_data.banked = '0;
         wr_data.app    = app_new;
      end else if (state_ff == ST_UPD2) begin
         wr_en   = 1'b1;
         wr_addr = hit_idx_ff;
         priority if (zero_ff || chg_ff) begin
            if (!zero_ff) begin
               wr_data.banked = bank_sum[TK_W] ? uat_pkg::MAX48 : bank_sum[TK_W-1:0];
            end
            wr_data.start = start_ff;
            wr_data.base  = ticks_ff;
            wr_data.last  = ticks_ff;
            wr_data.app   = app_new;
         end else if (gt_ff) begin
            wr_data.last = ticks_ff;
         end else begin
            wr_data.last = hit_data_ff.last;
         end
      end
   end

   uat_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------------------------------
   // Share divider: floor(10000 * row / total), row never exceeds total
   // ---------------------------------------------------------------------------------------
   assign div_start = (state_ff == ST_MUL);

   uat_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (uat_pkg::NUM_W'(best_val_ff) * uat_pkg::NUM_W'(uat_pkg::SHARE_SCALE)),
      .den   (total_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // ---------------------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------------------
   assign emit_fire = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ch.ready);
   assign last_row  = empty_ff || ((rows_done_ff + 1'b1) == nrows_ff);
   assign start_pass =
      (req_fire && ((req_ch.op == uat_pkg::OP_SAMPLE && running_ff) ||
                    req_ch.op == uat_pkg::OP_REPORT)) ||
      (state_ff == ST_SCAN_T && s3_vld_ff && s3_last_ff && count_nx != '0) ||
      (emit_fire && !last_row);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         running_ff <= 1'b0;
         full_ff    <= 1'b0;
         valid_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  unique case (req_ch.op)
                     uat_pkg::OP_SAMPLE: begin
                        if (running_ff) begin
                           pid_ff        <= req_ch.pid;
                           start_ff      <= req_ch.start_ticks;
                           ticks_ff      <= req_ch.ticks;
                           uid_ff        <= req_ch.uid;
                           hit_found_ff  <= 1'b0;
                           free_found_ff <= 1'b0;
                           state_ff      <= ST_SCAN_S;
                        end
                     end
                     uat_pkg::OP_REPORT: begin
                        total_ff <= '0;
                        count_ff <= '0;
                        state_ff <= ST_SCAN_T;
                     end
                     uat_pkg::OP_CLEAR_RUN: begin
                        valid_ff   <= '0;
                        full_ff    <= 1'b0;
                        running_ff <= 1'b1;
                     end
                     uat_pkg::OP_STOP: running_ff <= 1'b0;
                     uat_pkg::OP_CLEAR_STP: begin
                        valid_ff   <= '0;
                        full_ff    <= 1'b0;
                        running_ff <= 1'b0;
                     end
                     default: ;
                  endcase
               end
            end
            ST_SCAN_S: begin
               if (s1_vld_ff) begin
                  if (valid_ff[s1_idx_ff] && rd_data.pid == pid_ff && !hit_found_ff) begin
                     hit_found_ff <= 1'b1;
                     hit_idx_ff   <= s1_idx_ff;
                     hit_data_ff  <= rd_data;
                  end
                  if (!valid_ff[s1_idx_ff] && !free_found_ff) begin
                     free_found_ff <= 1'b1;
                     free_idx_ff   <= s1_idx_ff;
                  end
                  if (s1_last_ff) begin
                     state_ff <= ST_UPD1;
                  end
               end
            end
            ST_UPD1: begin
               zero_ff   <= (hit_data_ff.base == '0) && (hit_data_ff.last == '0);
               chg_ff    <= hit_data_ff.start != start_ff;
               gt_ff     <= ticks_ff > hit_data_ff.last;
               diff_u_ff <= (hit_data_ff.last >= hit_data_ff.base) ?
                            hit_data_ff.last - hit_data_ff.base : '0;
               priority if (hit_found_ff) begin
                  state_ff <= ST_UPD2;
               end else if (free_found_ff) begin
                  valid_ff[free_idx_ff] <= 1'b1;
                  state_ff              <= ST_IDLE;
               end else begin
                  full_ff  <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            ST_UPD2: state_ff <= ST_IDLE;
            ST_SCAN_T: begin
               if (s3_vld_ff) begin
                  if (qual) begin
                     total_ff <= total_sum[TOT_W] ? uat_pkg::MAX54 : total_sum[TOT_W-1:0];
                  end
                  count_ff <= count_nx;
                  if (s3_last_ff) begin
                     empty_ff      <= (count_nx == '0);
                     nrows_ff      <= (count_nx < ROW_CAP) ? count_nx : ROW_CAP;
                     rows_done_ff  <= '0;
                     best_found_ff <= 1'b0;
                     state_ff      <= (count_nx == '0) ? ST_EMIT : ST_SCAN_R;
                  end
               end
            end
            ST_SCAN_R: begin
               if (s3_vld_ff) begin
                  if (qual && after_prev && before_best) begin
                     best_found_ff <= 1'b1;
                     best_val_ff   <= s3_val_ff;
                     best_pid_ff   <= s3_pid_ff;
                     best_app_ff   <= s3_app_ff;
                  end
                  if (s3_last_ff) begin
                     state_ff <= ST_MUL;
                  end
               end
            end
            ST_MUL: state_ff <= ST_DIV;
            ST_DIV: begin
               if (div_done) begin
                  share_ff <= (div_quot > uat_pkg::SHARE_SCALE) ? uat_pkg::SHARE_SCALE
                                                                : div_quot;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (emit_fire) begin
                  rows_done_ff <= rows_done_ff + 1'b1;
                  if (last_row) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     prev_val_ff   <= best_val_ff;
                     prev_pid_ff   <= best_pid_ff;
                     best_found_ff <= 1'b0;
                     state_ff      <= ST_SCAN_R;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // ---------------------------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_row_valid_ff <= !empty_ff;
         rsp_pid_ff       <= empty_ff ? '0 : best_pid_ff;
         rsp_ticks_ff     <= empty_ff ? '0 : best_val_ff;
         rsp_share_ff     <= empty_ff ? '0 : share_ff;
         rsp_is_app_ff    <= empty_ff ? 1'b0 : best_app_ff;
         rsp_total_ff     <= empty_ff ? '0 : total_ff;
         rsp_full_ff      <= full_ff;
         rsp_last_ff      <= last_row;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.row_valid        = rsp_row_valid_ff;
   assign rsp_ch.row_pid          = rsp_pid_ff;
   assign rsp_ch.cpu_ticks        = rsp_ticks_ff;
   assign rsp_ch.share_hundredths = rsp_share_ff;
   assign rsp_ch.is_app           = rsp_is_app_ff;
   assign rsp_ch.total_ticks      = rsp_total_ff;
   assign rsp_ch.table_full       = rsp_full_ff;
   assign rsp_ch.last             = rsp_last_ff;

   // ---------------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------------
   a_upd2_has_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD2) |-> hit_found_ff)
      else $error("update of an entry without a lookup hit");

   // the empty report emits its single row with no counted rows
   a_rows_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_R || (state_ff == ST_EMIT && !empty_ff))
      |-> (rows_done_ff < nrows_ff))
      else $error("report emitted more rows than it counted");

   a_clear_valid: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_ch.op == uat_pkg::OP_CLEAR_RUN || req_ch.op == uat_pkg::OP_CLEAR_STP))
      |=> (valid_ff == '0) && !full_ff)
      else $error("clear left entries or the full flag behind");

   a_share_cap: assert property (@(posedge clock) disable iff (reset)
      emit_fire |=> (rsp_share_ff <= uat_pkg::SHARE_SCALE))
      else $error("share above one hundred percent");

endmodule

`default_nettype wire

FILE: rtl/uat_mem.sv
// Entry store: one write port, one read port, registered read data.
// Depends on uat_pkg for the entry layout.
`timescale 1ns / 1ps
`default_nettype none

module uat_mem #(
   parameter int DEPTH = uat_pkg::TABLE_DEPTH_DEF,
   parameter int AW    = 6
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire uat_pkg::entry_type wr_data,
   input  wire logic               rd_en,
   input  wire logic [AW-1:0]      rd_addr,
   output uat_pkg::entry_type      rd_data
);

   uat_pkg::entry_type entry_mem [DEPTH];
   uat_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/uat_div.sv
// Restoring divider for the share: one quotient bit per cycle.
// Depends on uat_pkg for widths. Quotient must fit SHR_W bits.
`timescale 1ns / 1ps
`default_nettype none

module uat_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [uat_pkg::NUM_W-1:0] num,
   input  wire logic [uat_pkg::TOT_W-1:0] den,
   output logic                           done,
   output logic [uat_pkg::SHR_W-1:0]      quot
);

   localparam int DW = uat_pkg::TOT_W + uat_pkg::SHR_W;
   localparam int SW = $clog2(uat_pkg::SHR_W);

   logic [DW-1:0]             rem_ff;
   logic [DW-1:0]             dsh_ff;
   logic [uat_pkg::SHR_W-1:0] q_ff;
   logic [SW-1:0]             step_ff;
   logic                      busy_ff;
   logic                      done_ff;
   logic                      ge;

   assign ge = rem_ff >= dsh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= SW'(uat_pkg::SHR_W - 1);
            rem_ff  <= DW'(num);
            dsh_ff  <= DW'(den) << (uat_pkg::SHR_W - 1);
            q_ff    <= '0;
         end else if (busy_ff) begin
            if (ge) begin
               rem_ff <= rem_ff - dsh_ff;
            end
            q_ff   <= {q_ff[uat_pkg::SHR_W-2:0], ge};
            dsh_ff <= dsh_ff >> 1;
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff - 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

`default_nettype wire
